FILE: rtl/otq_pkg.sv
// Shared constants, codes and types of the ordered timer queue.
package otq_pkg;

  localparam int TIMER_SLOTS = 16;
  localparam int SLOT_BITS   = 4;
  localparam int GEN_BITS    = 8;
  localparam int HANDLE_BITS = SLOT_BITS + GEN_BITS;
  localparam int TIME_BITS   = 64;
  localparam int IVL_BITS    = 32;
  localparam int MIN_BITS    = 20;
  localparam int OP_BITS     = 2;
  localparam int STATUS_BITS = 3;
  localparam int IN_DATA_BITS  = 176;
  localparam int OUT_DATA_BITS = 80;

  localparam logic [MIN_BITS-1:0] MIN_REARM_RESET = MIN_BITS'(100);
  localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(TIMER_SLOTS - 1);

  typedef enum logic [OP_BITS-1:0] {
    OP_ADD    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_ADDED     = 3'd0,
    ST_FULL      = 3'd1,
    ST_CANCELLED = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EXPIRED   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SETTLE,
    S_DECIDE,
    S_DLY1,
    S_DLY2,
    S_EMIT_EXP,
    S_EMIT_FINAL
  } state_t;

  typedef struct packed {
    status_t                status;
    logic [HANDLE_BITS-1:0] handle;
    logic                   earliest_changed;
    logic                   rearm_valid;
    logic [TIME_BITS-1:0]   rearm_delay;
    logic                   last;
  } res_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic scan_run;
    logic decide;
    logic dly1;
    logic dly2;
    logic push_exp;
    logic push_final;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    op_t  op;
    logic scan_last;
    logic free_found;
    logic earliest;
    logic pend_found;
    logic act_any;
  } sts_t;

endpackage

FILE: rtl/ordered_timer_queue.sv
// Top level of the ordered timer queue: controller, datapath, output register.
//
// Channel  | Direction | Handshake                   | Contents
// ---------+-----------+-----------------------------+---------------------------------
// s_*      | in        | s_tvalid / s_tready         | one command word (add, cancel, tick)
// m_*      | out       | m_tvalid / m_tready         | result words, m_tlast on the final one
// cfg_*    | in        | cfg_valid / cfg_ready       | min_rearm_delay, 20 bits
//
// Sequence: a cancel goes straight to the decision and the final word. An add
// first scans all 16 slots through the single read port of the slot memory;
// when it becomes the earliest, two delay stages follow. A tick does one full
// scan per expired timer to find the next earliest, then the summary word.
// Reset: all slots inactive, generations zero, min_rearm_delay 100.
// Stalls: the output register holds one word; a held word does not stop the next
// command being taken or a scan, but each emit state waits until the register can take its word.
// cfg_ready is always high; write it only while the queue is idle.
module ordered_timer_queue import otq_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // now_time[63:0], expire_time[127:64], reload_interval[159:128],
  // handle_in[171:160], zero pad above
  input  logic [IN_DATA_BITS-1:0]  s_tdata,
  // op
  input  logic [OP_BITS-1:0]       s_tuser,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // handle_out[11:0], earliest_changed[12], rearm_valid[13],
  // rearm_delay[77:14], zero pad above
  output logic [OUT_DATA_BITS-1:0] m_tdata,
  // status
  output logic [STATUS_BITS-1:0]   m_tuser,
  output logic                     m_tlast,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [MIN_BITS-1:0]      cfg_data
);

  cmd_t cmd;
  sts_t sts;
  res_t res;
  res_t obuf;
  logic obuf_valid;
  logic can_push;
  logic push;
  op_t  in_op;

  assign in_op     = op_t'(s_tuser);
  assign cfg_ready = 1'b1;
  // the output register takes a word when empty or draining this cycle
  assign can_push  = !obuf_valid || m_tready;
  assign push      = cmd.push_exp || cmd.push_final;

  otq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_op    (in_op),
    .can_push (can_push),
    .sts      (sts),
    .in_ready (s_tready),
    .cmd      (cmd)
  );

  otq_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .in_op       (in_op),
    .in_now      (s_tdata[63:0]),
    .in_expire   (s_tdata[127:64]),
    .in_interval (s_tdata[159:128]),
    .in_handle   (s_tdata[171:160]),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_wdata   (cfg_data),
    .sts         (sts),
    .res         (res)
  );

  // Hold the word until taken; load a fresh one whenever the controller pushes
  always_ff @(posedge clk) begin
    if (rst) begin
      obuf_valid <= 1'b0;
    end else if (push) begin
      obuf_valid <= 1'b1;
    end else if (m_tready) begin
      obuf_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) obuf <= res;
  end

  assign m_tvalid = obuf_valid;
  assign m_tdata  = {2'b00, obuf.rearm_delay, obuf.rearm_valid, obuf.earliest_changed,
                     obuf.handle};
  assign m_tuser  = obuf.status;
  assign m_tlast  = obuf.last;

  // A push never overwrites a word that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    push |-> (!obuf_valid || m_tready))
    else $error("result pushed over a held word");

  // No command is taken while the controller is still producing words
  a_accept_quiet: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |-> !push)
    else $error("command taken during result production");

  // earliest_changed only accompanies a successful add carrying a delay
  a_earliest_add: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[12]) |-> (m_tuser == ST_ADDED && m_tdata[13] && m_tlast))
    else $error("earliest_changed outside a successful add");

  // Every word that is not the final one carries the expired status
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (m_tuser == ST_EXPIRED))
    else $error("non-final word with a status other than expired");

endmodule

FILE: rtl/otq_ctrl.sv
// Sequencing state machine of the ordered timer queue.
module otq_ctrl import otq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  op_t  in_op,
  input  logic can_push,
  input  sts_t sts,
  output logic in_ready,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_op)
            OP_ADD, OP_TICK: state_next = S_SCAN;
            OP_CANCEL:       state_next = S_DECIDE;
            default:         state_next = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (sts.scan_last) state_next = S_SETTLE;
      end
      S_SETTLE: state_next = S_DECIDE;
      S_DECIDE: begin
        unique case (sts.op)
          OP_ADD: begin
            if (sts.free_found && sts.earliest) state_next = S_DLY1;
            else state_next = S_EMIT_FINAL;
          end
          OP_CANCEL: state_next = S_EMIT_FINAL;
          OP_TICK: begin
            priority if (sts.pend_found) state_next = S_EMIT_EXP;
            else if (sts.act_any) state_next = S_DLY1;
            else state_next = S_EMIT_FINAL;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_DLY1: state_next = S_DLY2;
      S_DLY2: state_next = S_EMIT_FINAL;
      S_EMIT_EXP: begin
        if (can_push) state_next = S_SCAN;
      end
      S_EMIT_FINAL: begin
        if (can_push) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = (state == S_IDLE);
    cmd.load       = (state == S_IDLE) && in_valid;
    cmd.scan_run   = (state == S_SCAN);
    cmd.decide     = (state == S_DECIDE);
    cmd.dly1       = (state == S_DLY1);
    cmd.dly2       = (state == S_DLY2);
    cmd.push_exp   = (state == S_EMIT_EXP) && can_push;
    cmd.push_final = (state == S_EMIT_FINAL) && can_push;
  end

endmodule

FILE: rtl/otq_dp.sv
// Slot storage, scan accumulator, delay arithmetic and result register.
module otq_dp import otq_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  input  op_t                    in_op,
  input  logic [TIME_BITS-1:0]   in_now,
  input  logic [TIME_BITS-1:0]   in_expire,
  input  logic [IVL_BITS-1:0]    in_interval,
  input  logic [HANDLE_BITS-1:0] in_handle,
  input  logic                   cfg_we,
  input  logic [MIN_BITS-1:0]    cfg_wdata,
  output sts_t                   sts,
  output res_t                   res
);

  // captured item
  op_t                    op_q;
  logic [TIME_BITS-1:0]   now_q;
  logic [TIME_BITS-1:0]   exp_q;
  logic [IVL_BITS-1:0]    iv_q;
  logic [HANDLE_BITS-1:0] hnd_q;
  logic [MIN_BITS-1:0]    min_q;

  // slot state
  logic [TIME_BITS-1:0] mem_exp [TIMER_SLOTS];
  logic [IVL_BITS-1:0]  mem_iv  [TIMER_SLOTS];
  logic [TIMER_SLOTS-1:0] active;
  logic [TIMER_SLOTS-1:0] taken;
  logic [GEN_BITS-1:0]  gen [TIMER_SLOTS];

  // scan
  logic [SLOT_BITS-1:0] cnt;
  logic                 acc_en;
  logic [SLOT_BITS-1:0] acc_idx;
  logic [TIME_BITS-1:0] rd_exp;
  logic [IVL_BITS-1:0]  rd_iv;

  logic                 pend_found;
  logic [SLOT_BITS-1:0] pend_slot;
  logic [TIME_BITS-1:0] pend_exp;
  logic [IVL_BITS-1:0]  pend_iv;
  logic                 act_any;
  logic [TIME_BITS-1:0] act_min;
  logic                 free_found;
  logic [SLOT_BITS-1:0] free_slot;

  logic [TIME_BITS-1:0] dly_base;
  logic [TIME_BITS-1:0] d1;

  logic [SLOT_BITS-1:0] sel_slot;
  logic [GEN_BITS-1:0]  gen_sel;
  logic                 match;
  logic                 earliest;
  logic [TIME_BITS-1:0] min64;
  logic [TIME_BITS:0]   reload_sum;
  logic [TIME_BITS-1:0] reload_exp;
  logic                 add_commit;
  logic                 reload_we;
  logic                 scan_clr;

  // word fields settled at the decision step
  status_t                dec_status;
  logic [HANDLE_BITS-1:0] dec_handle;
  logic                   dec_ec;
  logic                   dec_last;

  assign min64      = TIME_BITS'(min_q);
  assign scan_clr   = cmd.load || cmd.push_exp;
  assign earliest   = !act_any || (exp_q < act_min);
  assign add_commit = cmd.decide && (op_q == OP_ADD) && free_found;
  assign reload_we  = cmd.push_exp && (pend_iv != '0);
  assign reload_sum = {1'b0, now_q} + (TIME_BITS + 1)'(pend_iv);
  assign reload_exp = reload_sum[TIME_BITS] ? '1 : reload_sum[TIME_BITS-1:0];

  // one generation read port, steered by the operation in hand
  always_comb begin
    unique case (op_q)
      OP_CANCEL: sel_slot = hnd_q[SLOT_BITS-1:0];
      OP_ADD:    sel_slot = free_slot;
      default:   sel_slot = pend_slot;
    endcase
  end
  assign gen_sel = gen[sel_slot];
  assign match   = active[sel_slot] && (gen_sel == hnd_q[HANDLE_BITS-1:SLOT_BITS]);

  assign sts.op         = op_q;
  assign sts.scan_last  = cmd.scan_run && (cnt == LAST_SLOT);
  assign sts.free_found = free_found;
  assign sts.earliest   = earliest;
  assign sts.pend_found = pend_found;
  assign sts.act_any    = act_any;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= in_op;
      now_q <= in_now;
      exp_q <= in_expire;
      iv_q  <= in_interval;
      hnd_q <= in_handle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_q <= MIN_REARM_RESET;
    end else if (cfg_we) begin
      min_q <= cfg_wdata;
    end
  end

  // slot memories: one write port, one registered read port at the scan index
  always_ff @(posedge clk) begin
    if (add_commit) begin
      mem_exp[free_slot] <= exp_q;
      mem_iv[free_slot]  <= iv_q;
    end else if (reload_we) begin
      mem_exp[pend_slot] <= reload_exp;
    end
    rd_exp  <= mem_exp[cnt];
    rd_iv   <= mem_iv[cnt];
    acc_idx <= cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      acc_en <= 1'b0;
    end else begin
      acc_en <= cmd.scan_run;
      if (scan_clr) cnt <= '0;
      else if (cmd.scan_run) cnt <= cnt + 1'b1;
    end
  end

  // running minimum of pending and of active expiries, first free slot
  always_ff @(posedge clk) begin
    if (rst || scan_clr) begin
      pend_found <= 1'b0;
      act_any    <= 1'b0;
      free_found <= 1'b0;
    end else if (acc_en) begin
      if (active[acc_idx] && !taken[acc_idx] && (rd_exp <= now_q) &&
          (!pend_found || (rd_exp < pend_exp))) begin
        pend_found <= 1'b1;
        pend_slot  <= acc_idx;
        pend_exp   <= rd_exp;
        pend_iv    <= rd_iv;
      end
      if (active[acc_idx] && (!act_any || (rd_exp < act_min))) begin
        act_any <= 1'b1;
        act_min <= rd_exp;
      end
      if (!active[acc_idx] && !free_found) begin
        free_found <= 1'b1;
        free_slot  <= acc_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
      taken  <= '0;
      for (int i = 0; i < TIMER_SLOTS; i++) gen[i] <= '0;
    end else begin
      if (cmd.load) taken <= '0;
      if (add_commit) active[free_slot] <= 1'b1;
      if (cmd.decide && (op_q == OP_CANCEL) && match) begin
        active[sel_slot] <= 1'b0;
        gen[sel_slot]    <= gen_sel + 1'b1;
      end
      if (cmd.push_exp) begin
        taken[pend_slot] <= 1'b1;
        if (pend_iv == '0) begin
          active[pend_slot] <= 1'b0;
          gen[pend_slot]    <= gen[pend_slot] + 1'b1;
        end
      end
    end
  end

  // pick status, handle and end marker of the word being decided
  always_comb begin
    dec_status = ST_EXPIRED;
    dec_handle = '0;
    dec_ec     = 1'b0;
    dec_last   = 1'b1;
    unique case (op_q)
      OP_ADD: begin
        if (free_found) begin
          dec_status = ST_ADDED;
          dec_handle = {gen_sel, free_slot};
          dec_ec     = earliest;
        end else begin
          dec_status = ST_FULL;
        end
      end
      OP_CANCEL: begin
        if (match) begin
          dec_status = ST_CANCELLED;
          dec_handle = hnd_q;
        end else begin
          dec_status = ST_NOT_FOUND;
        end
      end
      default: begin
        if (pend_found) begin
          dec_handle = {gen_sel, pend_slot};
          dec_last   = 1'b0;
        end
      end
    endcase
  end

  // result register and delay arithmetic
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      dly_base             <= (op_q == OP_ADD) ? exp_q : act_min;
      res.status           <= dec_status;
      res.handle           <= dec_handle;
      res.earliest_changed <= dec_ec;
      res.rearm_valid      <= 1'b0;
      res.rearm_delay      <= '0;
      res.last             <= dec_last;
    end
    if (cmd.dly1) begin
      d1 <= (now_q < dly_base) ? (dly_base - now_q) : min64;
    end
    if (cmd.dly2) begin
      res.rearm_delay <= (d1 < min64) ? min64 : d1;
      res.rearm_valid <= 1'b1;
    end
  end

endmodule
